@@ hdl/perlin_noise_3d_defines.svh @@
// Assertion macros shared by the noise pipeline modules.
`ifndef PERLIN_NOISE_3D_DEFINES_SVH
`define PERLIN_NOISE_3D_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Plain property, checked at every clock edge outside reset.
`define PN3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Same-cycle implication, checked outside reset.
`define PN3_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PN3_ASSERT(lbl, prop, msg)
`define PN3_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/pn3_pkg.sv @@
// Shared constants and types of the 3D gradient noise pipeline.
`timescale 1ns / 1ps
package pn3_pkg;

  // Parameter defaults.
  localparam int unsigned TABLE_SIZE_DEF = 128;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int unsigned ENTRY_W = 6;   // hash table entry
  localparam int unsigned IDX_W   = 7;   // table index of a load word
  localparam int unsigned CELL_W  = 6;   // integer cell coordinate, wraps at 64
  localparam int unsigned HASH_W  = 7;   // entry plus cell coordinate
  localparam int unsigned OUT_W   = 19;  // noise result
  localparam int unsigned CORNERS = 8;

  // Quintic fade coefficients: 6t^5 - 15t^4 + 10t^3.
  localparam int unsigned FADE_K5 = 6;
  localparam int unsigned FADE_K4 = 15;
  localparam int unsigned FADE_K3 = 10;

  // Table write command that travels down the lookup chain.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } tbl_wr_t;

endpackage

@@ hdl/pn3_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module pn3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Storage has no reset; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hdl/pn3_fade.sv @@
// Three-stage pipeline for the quintic fade curve of one coordinate.
`timescale 1ns / 1ps
module pn3_fade import pn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   fade_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam logic signed [F+4:0] K4_ONE = (F+5)'(FADE_K4) << F;
  localparam logic signed [F+5:0] K3_ONE = (F+6)'(FADE_K3) << F;
  localparam logic [F+2:0]        K5     = (F+3)'(FADE_K5);

  logic        [F+2:0]   t6;
  logic signed [F+4:0]   a;
  logic signed [2*F+5:0] ta_d, ta_q;
  logic        [2*F-1:0] tt_d, tt_q;
  logic        [F-1:0]   t1_q;
  logic signed [F+5:0]   taf;
  logic signed [F+5:0]   b_sum;
  logic        [F+3:0]   b_d, b_q;
  logic        [2*F-1:0] t3p_d, t3p_q;
  logic        [2*F+3:0] fp_d, fp_q;

  // Stage 1: t*(6t - 15) and t*t.
  always_comb begin
    t6   = K5 * (F+3)'(t_i);
    a    = $signed({2'b00, t6}) - K4_ONE;
    ta_d = $signed({1'b0, t_i}) * a;
    tt_d = t_i * t_i;
  end

  // Stage 2: b = t*(6t - 15) + 10 and t^3.
  always_comb begin
    taf   = $signed(ta_q[2*F+5:F]);
    b_sum = taf + K3_ONE;
    b_d   = b_sum[F+3:0];
    t3p_d = tt_q[2*F-1:F] * t1_q;
  end

  // Stage 3: t^3 * b.
  always_comb begin
    fp_d = t3p_q[2*F-1:F] * b_q;
  end

  always_ff @(posedge clk_i) begin
    ta_q  <= ta_d;
    tt_q  <= tt_d;
    t1_q  <= t_i;
    b_q   <= b_d;
    t3p_q <= t3p_d;
    fp_q  <= fp_d;
  end

  assign fade_o = fp_q[2*F:F];

endmodule

@@ hdl/pn3_hash.sv @@
// Chained hash table lookups for the eight cube corners, one RAM copy per read pair.
`timescale 1ns / 1ps
`include "perlin_noise_3d_defines.svh"
module pn3_hash import pn3_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ev_i,
  input  tbl_wr_t                           wr_i,
  input  logic [CELL_W-1:0]                 cell_x_i,
  input  logic [CELL_W-1:0]                 cell_y_i,
  input  logic [CELL_W-1:0]                 cell_z_i,
  output logic                              ev_o,
  output logic [CORNERS-1:0][ENTRY_W-1:0]   hash_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [HASH_W-1:0] HASH_MAX = '1;

  logic                ev1_q, ev2_q, ev3_q;
  tbl_wr_t             wr1_q, wr2_q;
  logic [CELL_W-1:0]   cy1_q, cz1_q, cz2_q;

  logic [ENTRY_W-1:0]  l1a, l1b;
  logic [HASH_W-1:0]   cx_n;
  logic [HASH_W-1:0]   h2 [2];
  logic [ENTRY_W-1:0]  l2a [2];
  logic [ENTRY_W-1:0]  l2b [2];
  logic [HASH_W-1:0]   h3 [4];
  logic [ENTRY_W-1:0]  l3a [4];
  logic [ENTRY_W-1:0]  l3b [4];

  // Stage control: evaluate valids and pending table writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev1_q <= 1'b0;
      ev2_q <= 1'b0;
      ev3_q <= 1'b0;
      wr1_q <= '0;
      wr2_q <= '0;
    end else begin
      ev1_q <= ev_i;
      ev2_q <= ev1_q;
      ev3_q <= ev2_q;
      wr1_q <= wr_i;
      wr2_q <= wr1_q;
    end
  end

  // Cell coordinates follow the lookups.
  always_ff @(posedge clk_i) begin
    cy1_q <= cell_y_i;
    cz1_q <= cell_z_i;
    cz2_q <= cz1_q;
  end

  // Level 1: entries at x and x+1, written by a load word on entry.
  assign cx_n = {1'b0, cell_x_i} + HASH_W'(1);

  pn3_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_l1 (
    .clk_i     (clk_i),
    .we_i      (wr_i.en),
    .waddr_i   (AW'(wr_i.addr)),
    .wdata_i   (wr_i.data),
    .raddr_a_i (AW'(cell_x_i)),
    .raddr_b_i (AW'(cx_n)),
    .rdata_a_o (l1a),
    .rdata_b_o (l1b)
  );

  // Level 2: rows a and b, each read at h and h+1.
  assign h2[0] = {1'b0, l1a} + {1'b0, cy1_q};
  assign h2[1] = {1'b0, l1b} + {1'b0, cy1_q};

  for (genvar j = 0; j < 2; j++) begin : g_l2
    pn3_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_l2 (
      .clk_i     (clk_i),
      .we_i      (wr1_q.en),
      .waddr_i   (AW'(wr1_q.addr)),
      .wdata_i   (wr1_q.data),
      .raddr_a_i (AW'(h2[j])),
      .raddr_b_i (AW'(h2[j] + HASH_W'(1))),
      .rdata_a_o (l2a[j]),
      .rdata_b_o (l2b[j])
    );
  end

  // Level 3: corners aa, ba, ab, bb, each read at z and z+1.
  assign h3[0] = {1'b0, l2a[0]} + {1'b0, cz2_q};
  assign h3[1] = {1'b0, l2a[1]} + {1'b0, cz2_q};
  assign h3[2] = {1'b0, l2b[0]} + {1'b0, cz2_q};
  assign h3[3] = {1'b0, l2b[1]} + {1'b0, cz2_q};

  for (genvar k = 0; k < 4; k++) begin : g_l3
    pn3_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_l3 (
      .clk_i     (clk_i),
      .we_i      (wr2_q.en),
      .waddr_i   (AW'(wr2_q.addr)),
      .wdata_i   (wr2_q.data),
      .raddr_a_i (AW'(h3[k])),
      .raddr_b_i (AW'(h3[k] + HASH_W'(1))),
      .rdata_a_o (l3a[k]),
      .rdata_b_o (l3b[k])
    );
    // Corner index: bit 0 is x, bit 1 is y, bit 2 is z.
    assign hash_o[k]     = l3a[k];
    assign hash_o[k + 4] = l3b[k];
  end

  assign ev_o = ev3_q;

  // A load word and an evaluate word never share a stage.
  `PN3_ASSERT(a_stage1_excl, !(wr1_q.en && ev1_q), "load and evaluate share stage 1")
  `PN3_ASSERT(a_stage2_excl, !(wr2_q.en && ev2_q), "load and evaluate share stage 2")
  // The z+1 reads of level 3 stay inside the 7-bit index range.
  `PN3_ASSERT_IMPLIES(a_hash_range, ev2_q,
    (h3[0] != HASH_MAX && h3[1] != HASH_MAX && h3[2] != HASH_MAX && h3[3] != HASH_MAX),
    "level 3 index overflow")

endmodule

@@ hdl/pn3_blend.sv @@
// Corner gradients and the trilinear blend, one lerp level per stage.
`timescale 1ns / 1ps
`include "perlin_noise_3d_defines.svh"
module pn3_blend import pn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  input  logic [CORNERS-1:0][ENTRY_W-1:0] hash_i,
  input  logic [FRAC_BITS-1:0]            frac_x_i,
  input  logic [FRAC_BITS-1:0]            frac_y_i,
  input  logic [FRAC_BITS-1:0]            frac_z_i,
  input  logic [FRAC_BITS:0]              fade_u_i,
  input  logic [FRAC_BITS:0]              fade_v_i,
  input  logic [FRAC_BITS:0]              fade_w_i,
  output logic                            noise_valid_o,
  output logic signed [OUT_W-1:0]         noise_value_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned GW = F + 3;          // gradient and lerp values
  localparam int unsigned DW = GW + 1;         // lerp difference
  localparam int unsigned PW = F + 2 + DW;     // fade times difference
  localparam int unsigned RW = (GW > OUT_W) ? GW : OUT_W;
  localparam logic signed [GW-1:0] ONE_G   = GW'(1) << F;
  localparam logic signed [GW-1:0] TWO_G   = GW'(2) << F;
  localparam logic signed [GW-1:0] NEG_TWO = -TWO_G;
  localparam logic        [F:0]    ONE_W   = (F+1)'(1) << F;
  localparam logic [3:0] H_XY_LAST = 4'd7;
  localparam logic [3:0] H_Y_LAST  = 4'd3;
  localparam logic [3:0] H_XZ_A    = 4'd12;
  localparam logic [3:0] H_XZ_B    = 4'd14;

  // Dot product with one of the sixteen gradient directions.
  function automatic logic signed [GW-1:0] grad_dot(
    input logic [3:0]           h,
    input logic signed [GW-1:0] x,
    input logic signed [GW-1:0] y,
    input logic signed [GW-1:0] z
  );
    logic signed [GW-1:0] a;
    logic signed [GW-1:0] b;
    a = (h <= H_XY_LAST) ? x : y;
    case (h) inside
      [4'd0:H_Y_LAST]: b = y;
      H_XZ_A, H_XZ_B:  b = x;
      default:         b = z;
    endcase
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  logic signed [GW-1:0] ox [2];
  logic signed [GW-1:0] oy [2];
  logic signed [GW-1:0] oz [2];
  logic signed [GW-1:0] g_d [CORNERS];
  logic signed [GW-1:0] g_q [CORNERS];
  logic [F:0]           u4_q, v4_q, w4_q, v5_q, w5_q, w6_q;

  logic signed [DW-1:0] dx [4];
  logic signed [PW-1:0] px_d [4];
  logic signed [PW-1:0] px_q [4];
  logic signed [GW-1:0] pa_q [4];

  logic signed [GW-1:0] lx [4];
  logic signed [DW-1:0] dy [2];
  logic signed [PW-1:0] py_d [2];
  logic signed [PW-1:0] py_q [2];
  logic signed [GW-1:0] pb_q [2];

  logic signed [GW-1:0] ly [2];
  logic signed [DW-1:0] dz;
  logic signed [PW-1:0] pz_d, pz_q;
  logic signed [GW-1:0] pc_q;

  logic signed [GW-1:0] r_d, r_q;
  logic signed [RW-1:0] r_ext;
  logic                 vg_q, vx_q, vy_q, vz_q, vo_q;

  // Gradient stage: offsets from the near and far corner on each axis.
  always_comb begin
    ox[0] = $signed({3'b000, frac_x_i});
    oy[0] = $signed({3'b000, frac_y_i});
    oz[0] = $signed({3'b000, frac_z_i});
    ox[1] = ox[0] - ONE_G;
    oy[1] = oy[0] - ONE_G;
    oz[1] = oz[0] - ONE_G;
    for (int c = 0; c < CORNERS; c++) begin
      g_d[c] = grad_dot(hash_i[c][3:0], ox[c % 2], oy[(c / 2) % 2], oz[c / 4]);
    end
  end

  // Lerp along x: multiply by the x fade.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx[i]   = DW'(g_q[2*i+1]) - DW'(g_q[2*i]);
      px_d[i] = $signed({1'b0, u4_q}) * dx[i];
    end
  end

  // Finish x, lerp along y.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lx[i] = pa_q[i] + $signed(px_q[i][F+GW-1:F]);
    end
    for (int j = 0; j < 2; j++) begin
      dy[j]   = DW'(lx[2*j+1]) - DW'(lx[2*j]);
      py_d[j] = $signed({1'b0, v5_q}) * dy[j];
    end
  end

  // Finish y, lerp along z.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ly[j] = pb_q[j] + $signed(py_q[j][F+GW-1:F]);
    end
    dz   = DW'(ly[1]) - DW'(ly[0]);
    pz_d = $signed({1'b0, w6_q}) * dz;
  end

  // Finish z.
  assign r_d = pc_q + $signed(pz_q[F+GW-1:F]);

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    g_q  <= g_d;
    u4_q <= fade_u_i;
    v4_q <= fade_v_i;
    w4_q <= fade_w_i;
    px_q <= px_d;
    for (int i = 0; i < 4; i++) begin
      pa_q[i] <= g_q[2*i];
    end
    v5_q <= v4_q;
    w5_q <= w4_q;
    py_q <= py_d;
    pb_q[0] <= lx[0];
    pb_q[1] <= lx[2];
    w6_q <= w5_q;
    pz_q <= pz_d;
    pc_q <= ly[0];
    r_q  <= r_d;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vx_q <= 1'b0;
      vy_q <= 1'b0;
      vz_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vg_q <= vld_i;
      vx_q <= vg_q;
      vy_q <= vx_q;
      vz_q <= vy_q;
      vo_q <= vz_q;
    end
  end

  assign r_ext         = RW'(r_q);
  assign noise_value_o = r_ext[OUT_W-1:0];
  assign noise_valid_o = vo_q;

  // Fade weights never exceed one.
  `PN3_ASSERT_IMPLIES(a_fade_range, vld_i,
    (fade_u_i <= ONE_W && fade_v_i <= ONE_W && fade_w_i <= ONE_W), "fade weight above one")
  // The blend stays within the range of the corner gradients.
  `PN3_ASSERT_IMPLIES(a_out_range, vo_q, (r_q >= NEG_TWO && r_q <= TWO_G),
    "noise result out of range")
  // Every result comes from an item that entered through vld_i and passed vg_q, vx_q, vy_q and vz_q into vo_q.
  `PN3_ASSERT_IMPLIES(a_latency, vo_q, $past(vld_i, 5), "result without a matching item")

endmodule

@@ hdl/perlin_noise_3d.sv @@
// Top level of the 3D gradient noise pipeline with a loadable hash table.
`timescale 1ns / 1ps
// Takes one word per clock and never raises busy. A load word (kind_i = 1)
// writes entry_index_i of the 128-entry hash table and gives no result; an
// evaluate word (kind_i = 0) gives its noise_value_o with noise_valid_o high
// for one cycle, in order, once through the hash and blend stages. The receiver cannot
// hold results off: each result must be taken in the one cycle that
// noise_valid_o marks. A load affects every evaluate word accepted after it
// and none accepted before it. The table is not cleared at reset: every entry
// that an evaluation touches must have been loaded first. Throughput is one
// word per cycle, set by the eight-stage pipeline in which each of the three
// table lookup levels reads its own RAM copies, written in step as a load
// word passes that level.
module perlin_noise_3d import pn3_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_y_i,
  input  logic signed [31:0]      pos_z_i,
  input  logic [IDX_W-1:0]        entry_index_i,
  input  logic [ENTRY_W-1:0]      entry_value_i,
  output logic                    noise_valid_o,
  output logic signed [OUT_W-1:0] noise_value_o
);

  localparam int unsigned F = FRAC_BITS;

  logic                           accept;
  logic                           ev;
  tbl_wr_t                        wr;
  logic                           ev3;
  logic [CORNERS-1:0][ENTRY_W-1:0] hash;
  logic [2:0][F-1:0]              fx_q, fy_q, fz_q;
  logic [F:0]                     fade_u, fade_v, fade_w;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign ev     = accept && !kind_i;

  always_comb begin
    wr.en   = accept && kind_i;
    wr.addr = entry_index_i;
    wr.data = entry_value_i;
  end

  // Hash chain: integer cells wrap at 64.
  pn3_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ev_i     (ev),
    .wr_i     (wr),
    .cell_x_i (pos_x_i[F+CELL_W-1:F]),
    .cell_y_i (pos_y_i[F+CELL_W-1:F]),
    .cell_z_i (pos_z_i[F+CELL_W-1:F]),
    .ev_o     (ev3),
    .hash_o   (hash)
  );

  // Fade curves, aligned with the hash chain.
  pn3_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk_i  (clk_i),
    .t_i    (pos_x_i[F-1:0]),
    .fade_o (fade_u)
  );

  pn3_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk_i  (clk_i),
    .t_i    (pos_y_i[F-1:0]),
    .fade_o (fade_v)
  );

  pn3_fade #(.FRAC_BITS(F)) u_fade_z (
    .clk_i  (clk_i),
    .t_i    (pos_z_i[F-1:0]),
    .fade_o (fade_w)
  );

  // Fractions pass through the delay registers fx_q, fy_q and fz_q to line up with the corner hashes.
  always_ff @(posedge clk_i) begin
    fx_q <= {fx_q[1:0], pos_x_i[F-1:0]};
    fy_q <= {fy_q[1:0], pos_y_i[F-1:0]};
    fz_q <= {fz_q[1:0], pos_z_i[F-1:0]};
  end

  // Gradients and trilinear blend.
  pn3_blend #(.FRAC_BITS(F)) u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (ev3),
    .hash_i        (hash),
    .frac_x_i      (fx_q[2]),
    .frac_y_i      (fy_q[2]),
    .frac_z_i      (fz_q[2]),
    .fade_u_i      (fade_u),
    .fade_v_i      (fade_v),
    .fade_w_i      (fade_w),
    .noise_valid_o (noise_valid_o),
    .noise_value_o (noise_value_o)
  );

endmodule

@@ tb/perlin_noise_3d_tb.sv @@
// Self-checking testbench for the 3D gradient noise pipeline with its loadable hash table.
`timescale 1ns / 1ps

import pn3_pkg::*;

// Mirrors the hash table, predicts each noise word and checks the block's results.
class noise_checker;
  localparam int     FRAC = FRAC_BITS_DEF;
  localparam longint ONE  = longint'(1) << FRAC;

  logic [ENTRY_W-1:0]      table_copy [TABLE_SIZE_DEF];
  logic signed [OUT_W-1:0] pending_noise [$];
  int unsigned             mismatches;

  function new();
    for (int i = 0; i < TABLE_SIZE_DEF; i++) table_copy[i] = '0;
    mismatches = 0;
  endfunction

  // Fixed-point product; the arithmetic shift rounds toward minus infinity.
  function longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  // Quintic fade 6t^5 - 15t^4 + 10t^3 in the same order of operations as the block.
  function longint fade(longint t);
    longint a, b, t2, t3;
    a  = FADE_K5 * t - FADE_K4 * ONE;
    b  = fx_mul(t, a) + FADE_K3 * ONE;
    t2 = fx_mul(t, t);
    t3 = fx_mul(t2, t);
    return fx_mul(t3, b);
  endfunction

  function longint lerp(longint wt, longint p, longint q);
    return p + fx_mul(wt, q - p);
  endfunction

  // One of the sixteen gradient dot products, picked by the low four hash bits.
  function longint grad(int unsigned hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint     a, b;
    h = hv[3:0];
    a = (h < 8) ? x : y;
    b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  function int unsigned rd(int unsigned idx);
    return int'(table_copy[idx]);
  endfunction

  function logic signed [OUT_W-1:0] predict_noise(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
    int unsigned cx, cy, cz, ha, hb, haa, hab, hba, hbb;
    longint      fx, fy, fz, gx, gy, gz, u, v, w, near_z, far_z, r;
    cx = x[FRAC +: CELL_W];
    cy = y[FRAC +: CELL_W];
    cz = z[FRAC +: CELL_W];
    fx = longint'(x[FRAC-1:0]);
    fy = longint'(y[FRAC-1:0]);
    fz = longint'(z[FRAC-1:0]);
    gx = fx - ONE;
    gy = fy - ONE;
    gz = fz - ONE;
    u  = fade(fx);
    v  = fade(fy);
    w  = fade(fz);
    // Chained lookups hash the eight cube corners.
    ha  = rd(cx) + cy;
    haa = rd(ha) + cz;
    hab = rd(ha + 1) + cz;
    hb  = rd(cx + 1) + cy;
    hba = rd(hb) + cz;
    hbb = rd(hb + 1) + cz;
    near_z = lerp(v, lerp(u, grad(rd(haa), fx, fy, fz), grad(rd(hba), gx, fy, fz)),
                     lerp(u, grad(rd(hab), fx, gy, fz), grad(rd(hbb), gx, gy, fz)));
    far_z  = lerp(v, lerp(u, grad(rd(haa + 1), fx, fy, gz), grad(rd(hba + 1), gx, fy, gz)),
                     lerp(u, grad(rd(hab + 1), fx, gy, gz), grad(rd(hbb + 1), gx, gy, gz)));
    r = lerp(w, near_z, far_z);
    return r[OUT_W-1:0];
  endfunction

  // An accepted word either updates the table copy or queues its expected noise.
  function void note_word(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
    if (kind) begin
      table_copy[idx] = val;
    end else begin
      pending_noise = {pending_noise, predict_noise(x, y, z)};
    end
  endfunction

  // Compares one result word with the oldest expected noise value.
  function void check_noise(logic signed [OUT_W-1:0] actual);
    logic signed [OUT_W-1:0] expected;
    if (pending_noise.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected noise word %0d with none pending", actual);
    end else begin
      expected = pending_noise.pop_front();
      if (actual !== expected) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("noise mismatch: expected %0d, got %0d", expected, actual);
        end
      end
    end
  endfunction
endclass

module perlin_noise_3d_tb;
  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam int FILL_ZERO   = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_RANDOM = 2;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    kind_i;
  logic signed [31:0]      pos_x_i;
  logic signed [31:0]      pos_y_i;
  logic signed [31:0]      pos_z_i;
  logic [IDX_W-1:0]        entry_index_i;
  logic [ENTRY_W-1:0]      entry_value_i;
  logic                    noise_valid_o;
  logic signed [OUT_W-1:0] noise_value_o;

  noise_checker checker_h;
  bit           gaps_on;
  int unsigned  drain_cycles;

  perlin_noise_3d DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .noise_valid_o (noise_valid_o),
    .noise_value_o (noise_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are checked before the word accepted at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (noise_valid_o) checker_h.check_noise(noise_value_o);
      if (start && !busy) begin
        checker_h.note_word(kind_i, pos_x_i, pos_y_i, pos_z_i, entry_index_i, entry_value_i);
      end
    end
  end

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= kind;
    pos_x_i       <= x;
    pos_y_i       <= y;
    pos_z_i       <= z;
    entry_index_i <= idx;
    entry_value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Writes every table entry; the zero and ones modes give the two extreme fills.
  task automatic fill_table(int mode);
    logic [ENTRY_W-1:0] val;
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      case (mode)
        FILL_ZERO: val = '0;
        FILL_ONES: val = '1;
        default:   val = ENTRY_W'($urandom_range(0, 63));
      endcase
      send_word(KIND_LOAD, $urandom(), $urandom(), $urandom(), i[IDX_W-1:0], val);
    end
  endtask

  // Points at the extremes: zero, both ends of the range, cell 63, wrap to cell 0,
  // negative coordinates and fractions at zero, one half and just under one.
  task automatic eval_extremes();
    send_word(KIND_EVAL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0, '0);
    send_word(KIND_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
    send_word(KIND_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '1);
    send_word(KIND_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '0);
    send_word(KIND_EVAL, 32'h003F_FFFF, 32'h003F_8000, 32'h0040_0000, '0, '0);
    send_word(KIND_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, '0, '0);
    send_word(KIND_EVAL, 32'hFFFF_0000, 32'h0040_0000, 32'h0000_FFFF, '0, '0);
  endtask

  // Random coordinate, biased toward fractions at their edges.
  function automatic logic [31:0] pick_coord();
    logic [15:0] whole;
    whole = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0:       return {whole, 16'h0000};
      1:       return {whole, 16'hFFFF};
      2:       return {whole, 16'h8000};
      3:       return {whole, 16'h0001};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    checker_h     = new();
    gaps_on       = 1'b1;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= KIND_EVAL;
    pos_x_i       <= '0;
    pos_y_i       <= '0;
    pos_z_i       <= '0;
    entry_index_i <= '0;
    entry_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under an all-zero, an all-ones and a random table.
    fill_table(FILL_ZERO);
    eval_extremes();
    fill_table(FILL_ONES);
    eval_extremes();
    fill_table(FILL_RANDOM);
    eval_extremes();

    // Random mix of evaluations and table rewrites; the middle runs without gaps.
    for (int n = 0; n < 750; n++) begin
      gaps_on = !(n >= 200 && n < 500);
      if ($urandom_range(0, 99) < 15) begin
        send_word(KIND_LOAD, $urandom(), $urandom(), $urandom(),
                  IDX_W'($urandom_range(0, 127)), ENTRY_W'($urandom_range(0, 63)));
      end else begin
        send_word(KIND_EVAL, pick_coord(), pick_coord(), pick_coord(),
                  IDX_W'($urandom_range(0, 127)), ENTRY_W'($urandom_range(0, 63)));
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a few more cycles for stray results.
    drain_cycles = 0;
    while (checker_h.pending_noise.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (16) @(posedge clk_i);
    if (checker_h.pending_noise.size() != 0) begin
      checker_h.mismatches++;
      $display("%0d noise words never arrived", checker_h.pending_noise.size());
    end

    if (checker_h.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the longest correct run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
